[hw/rtl/sld_pkg.sv]
`timescale 1ns / 1ps
package sld_pkg;
   localparam int MAX_LINE = 256;
   localparam int POS_W    = $clog2(MAX_LINE);
   localparam int LEN_W    = POS_W + 1;
   localparam int ADDR_W   = POS_W + 1;

   localparam logic [LEN_W-1:0] NO_MISMATCH = LEN_W'(MAX_LINE);
   localparam logic [LEN_W:0]   LONG_LIMIT  = (LEN_W + 1)'(MAX_LINE - 1);

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_VT      = 8'd11;
   localparam logic [7:0] CHAR_FF      = 8'd12;
   localparam logic [7:0] CHAR_CR      = 8'd13;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_LONG   = 2'd1;
   localparam logic [1:0] ERR_NO_TAB = 2'd2;

   typedef enum logic {CMD_EMIT, CMD_ERROR} cmd_op_type;

   typedef struct packed {
      cmd_op_type       op;
      logic             half;
      logic [LEN_W-1:0] len;
      logic [31:0]      count;
      logic [1:0]       code;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  nbytes;
      logic [31:0] count;
      logic        last;
      logic [1:0]  code;
   } piece_type;

   typedef enum logic [1:0] {PARSE_SKIP, PARSE_DIGITS, PARSE_DONE} parse_state_type;
   typedef enum logic [1:0] {BACK_IDLE, BACK_READ, BACK_CAPT, BACK_PUSH} back_state_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [31:0] sat_mac10(input logic [31:0] p, input logic [3:0] d);
      logic [35:0] s;
      s = ({4'b0, p} << 3) + ({4'b0, p} << 1) + {32'b0, d};
      return (s[35:32] != 4'd0) ? 32'hFFFF_FFFF : s[31:0];
   endfunction
endpackage

[hw/rtl/sld_front.sv]
`timescale 1ns / 1ps
module sld_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic                kind,
   input  logic [7:0]          data_byte,
   output logic                full,
   input  logic                csr_valid,
   input  logic                csr_merge_mode,
   input  logic                back_busy,
   input  sld_pkg::rd_req_type back_rd,
   output logic [7:0]          rd_data,
   output logic                cmd_push,
   output sld_pkg::cmd_type    cmd
);
   import sld_pkg::*;

   logic [7:0] mem [2*MAX_LINE];
   logic [7:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic mem_we;
   logic [ADDR_W-1:0] wr_addr;

   logic merge_ff;
   logic s1_valid_ff, s1_kind_ff, s1_long_ff;
   logic [7:0] s1_byte_ff;
   logic [LEN_W-1:0] s1_pos_ff;
   logic [LEN_W-1:0] line_ff, line_in;
   logic held_sel_ff, held_sel_in;
   logic [LEN_W-1:0] held_len_ff, held_len_in;
   logic [31:0] held_cnt_ff, held_cnt_in;
   logic [LEN_W-1:0] mism_ff, mism_in;
   logic tab_seen_ff, tab_seen_in;
   logic [LEN_W-1:0] tab_pos_ff, tab_pos_in;
   logic [31:0] parsed_ff, parsed_in;
   logic neg_ff, neg_in;
   parse_state_type pstate_ff, pstate_in;
   logic stopped_ff, stopped_in;
   logic flush_pend_ff, flush_pend_in;

   logic accept, s2_go, close_req, is_digit, is_space;
   logic [LEN_W-1:0] key_len;
   logic [31:0] line_cnt;
   logic [LEN_W:0] next_len;

   assign full = (s1_valid_ff && (s1_kind_ff == KIND_END || s1_byte_ff == CHAR_NEWLINE))
                 || flush_pend_ff || back_busy;
   assign accept = push && !full;
   assign next_len = {1'b0, line_ff} + 1'b1;
   assign rd_addr = back_rd.en ? back_rd.addr : {held_sel_ff, line_ff[POS_W-1:0]};
   assign rd_data = rd_data_ff;
   assign wr_addr = {~held_sel_ff, s1_pos_ff[POS_W-1:0]};

   assign s2_go = s1_valid_ff && !stopped_ff;
   assign close_req = s2_go && ((s1_kind_ff == KIND_BYTE && !s1_long_ff
                                 && s1_byte_ff == CHAR_NEWLINE)
                                || (s1_kind_ff == KIND_END && s1_pos_ff != '0));
   assign key_len  = merge_ff ? tab_pos_ff : s1_pos_ff;
   assign line_cnt = merge_ff ? (neg_ff ? 32'd0 : parsed_ff) : 32'd1;
   assign is_digit = s1_byte_ff >= CHAR_ZERO && s1_byte_ff <= CHAR_NINE;
   assign is_space = s1_byte_ff == CHAR_SPACE || s1_byte_ff == CHAR_VT
                     || s1_byte_ff == CHAR_FF || s1_byte_ff == CHAR_CR;

   always_comb begin
      line_in       = line_ff;
      held_sel_in   = held_sel_ff;
      held_len_in   = held_len_ff;
      held_cnt_in   = held_cnt_ff;
      mism_in       = mism_ff;
      tab_seen_in   = tab_seen_ff;
      tab_pos_in    = tab_pos_ff;
      parsed_in     = parsed_ff;
      neg_in        = neg_ff;
      pstate_in     = pstate_ff;
      stopped_in    = stopped_ff;
      flush_pend_in = flush_pend_ff;
      mem_we        = 1'b0;
      cmd_push      = 1'b0;
      cmd           = '0;

      if (accept) begin
         if (kind == KIND_END || data_byte == CHAR_NEWLINE) begin
            line_in = '0;
         end else begin
            line_in = next_len[LEN_W-1:0];
         end
      end

      // Second half of an end-of-input word: send out whatever run is held.
      if (flush_pend_ff) begin
         if (held_len_ff != '0) begin
            cmd_push  = 1'b1;
            cmd.op    = CMD_EMIT;
            cmd.half  = held_sel_ff;
            cmd.len   = held_len_ff;
            cmd.count = held_cnt_ff;
         end
         held_len_in   = '0;
         held_cnt_in   = '0;
         flush_pend_in = 1'b0;
      end

      if (s2_go) begin
         if (s1_kind_ff == KIND_BYTE && s1_long_ff) begin
            cmd_push   = 1'b1;
            cmd.op     = CMD_ERROR;
            cmd.code   = ERR_LONG;
            stopped_in = 1'b1;
         end else if (close_req && merge_ff && !tab_seen_ff) begin
            cmd_push   = 1'b1;
            cmd.op     = CMD_ERROR;
            cmd.code   = ERR_NO_TAB;
            stopped_in = 1'b1;
         end else if (close_req || s1_kind_ff == KIND_END) begin
            if (close_req) begin
               if (key_len == held_len_ff && mism_ff >= key_len) begin
                  held_cnt_in = sat_add(held_cnt_ff, line_cnt);
               end else begin
                  if (held_len_ff != '0) begin
                     cmd_push  = 1'b1;
                     cmd.op    = CMD_EMIT;
                     cmd.half  = held_sel_ff;
                     cmd.len   = held_len_ff;
                     cmd.count = held_cnt_ff;
                  end
                  held_sel_in = ~held_sel_ff;
                  held_len_in = key_len;
                  held_cnt_in = line_cnt;
               end
               mism_in     = NO_MISMATCH;
               tab_seen_in = 1'b0;
               tab_pos_in  = '0;
               parsed_in   = '0;
               neg_in      = 1'b0;
               pstate_in   = PARSE_SKIP;
            end
            if (s1_kind_ff == KIND_END) begin
               flush_pend_in = 1'b1;
            end
         end else begin
            mem_we = 1'b1;
            if (mism_ff == NO_MISMATCH
                && (s1_pos_ff >= held_len_ff || rd_data_ff != s1_byte_ff)) begin
               mism_in = s1_pos_ff;
            end
            if (s1_byte_ff == CHAR_TAB) begin
               tab_seen_in = 1'b1;
               tab_pos_in  = s1_pos_ff;
               parsed_in   = '0;
               neg_in      = 1'b0;
               pstate_in   = PARSE_SKIP;
            end else if (tab_seen_ff) begin
               unique case (pstate_ff)
                  PARSE_SKIP: begin
                     if (is_space) begin
                        pstate_in = PARSE_SKIP;
                     end else if (s1_byte_ff == CHAR_PLUS) begin
                        pstate_in = PARSE_DIGITS;
                     end else if (s1_byte_ff == CHAR_MINUS) begin
                        neg_in    = 1'b1;
                        pstate_in = PARSE_DIGITS;
                     end else if (is_digit) begin
                        parsed_in = sat_mac10(parsed_ff, 4'(s1_byte_ff - CHAR_ZERO));
                        pstate_in = PARSE_DIGITS;
                     end else begin
                        pstate_in = PARSE_DONE;
                     end
                  end
                  PARSE_DIGITS: begin
                     if (is_digit) begin
                        parsed_in = sat_mac10(parsed_ff, 4'(s1_byte_ff - CHAR_ZERO));
                     end else begin
                        pstate_in = PARSE_DONE;
                     end
                  end
                  PARSE_DONE: pstate_in = PARSE_DONE;
                  default:    pstate_in = PARSE_DONE;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[wr_addr] <= s1_byte_ff;
      end
      if (accept) begin
         s1_kind_ff <= kind;
         s1_byte_ff <= data_byte;
         s1_pos_ff  <= line_ff;
         s1_long_ff <= next_len >= LONG_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_ff      <= 1'b0;
         s1_valid_ff   <= 1'b0;
         line_ff       <= '0;
         held_sel_ff   <= 1'b0;
         held_len_ff   <= '0;
         held_cnt_ff   <= '0;
         mism_ff       <= NO_MISMATCH;
         tab_seen_ff   <= 1'b0;
         tab_pos_ff    <= '0;
         parsed_ff     <= '0;
         neg_ff        <= 1'b0;
         pstate_ff     <= PARSE_SKIP;
         stopped_ff    <= 1'b0;
         flush_pend_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            merge_ff <= csr_merge_mode;
         end
         s1_valid_ff   <= accept;
         line_ff       <= line_in;
         held_sel_ff   <= held_sel_in;
         held_len_ff   <= held_len_in;
         held_cnt_ff   <= held_cnt_in;
         mism_ff       <= mism_in;
         tab_seen_ff   <= tab_seen_in;
         tab_pos_ff    <= tab_pos_in;
         parsed_ff     <= parsed_in;
         neg_ff        <= neg_in;
         pstate_ff     <= pstate_in;
         stopped_ff    <= stopped_in;
         flush_pend_ff <= flush_pend_in;
      end
   end
endmodule

[hw/rtl/sld_cmd_queue.sv]
`timescale 1ns / 1ps
module sld_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sld_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             not_empty,
   output sld_pkg::cmd_type head
);
   import sld_pkg::*;

   cmd_type ent_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign not_empty = cnt_ff != 2'd0;
   assign head = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[hw/rtl/sld_back.sv]
`timescale 1ns / 1ps
module sld_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  sld_pkg::cmd_type    cmd,
   output logic                cmd_pop,
   output logic                busy,
   output sld_pkg::rd_req_type rd_req,
   input  logic [7:0]          rd_data,
   input  logic                out_pop,
   output logic                out_empty,
   output sld_pkg::piece_type  out_piece
);
   import sld_pkg::*;

   back_state_type state_ff, state_in;
   cmd_type cmd_ff;
   logic [LEN_W-1:0] pos_ff;
   logic [63:0] word_ff;
   piece_type slot_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic out_space, out_push, piece_end, run_end;
   logic [LEN_W-1:0] pos_next;
   piece_type piece;

   assign out_space = cnt_ff != 2'd2;
   assign out_empty = cnt_ff == 2'd0;
   assign out_piece = slot_ff[rd_ptr_ff];
   assign busy      = state_ff != BACK_IDLE;
   assign pos_next  = pos_ff + 1'b1;
   assign run_end   = pos_next == cmd_ff.len;
   assign piece_end = pos_ff[2:0] == 3'd7 || run_end;

   always_comb begin
      if (cmd_ff.op == CMD_ERROR) begin
         piece      = '0;
         piece.last = 1'b1;
         piece.code = cmd_ff.code;
      end else begin
         piece.key    = word_ff;
         piece.nbytes = {1'b0, pos_ff[2:0]} + 4'd1;
         piece.count  = cmd_ff.count;
         piece.last   = run_end;
         piece.code   = ERR_NONE;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               state_in = (cmd.op == CMD_ERROR) ? BACK_PUSH : BACK_READ;
            end
         end
         BACK_READ: state_in = BACK_CAPT;
         BACK_CAPT: state_in = piece_end ? BACK_PUSH : BACK_READ;
         BACK_PUSH: begin
            if (out_space) begin
               state_in = (piece.last) ? BACK_IDLE : BACK_READ;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop     = state_ff == BACK_IDLE && cmd_valid;
      rd_req.en   = state_ff == BACK_READ;
      rd_req.addr = {cmd_ff.half, pos_ff[POS_W-1:0]};
      out_push    = state_ff == BACK_PUSH && out_space;
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff  <= cmd;
         pos_ff  <= '0;
         word_ff <= '0;
      end else if (state_ff == BACK_CAPT) begin
         word_ff[pos_ff[2:0]*8 +: 8] <= rd_data;
         if (!piece_end) begin
            pos_ff <= pos_next;
         end
      end else if (out_push) begin
         pos_ff  <= pos_next;
         word_ff <= '0;
      end
      if (out_push) begin
         slot_ff[wr_ptr_ff] <= piece;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (out_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (out_pop && !out_empty) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, out_push} - {1'b0, out_pop && !out_empty};
      end
   end
endmodule

[hw/rtl/sorted_line_dedup_counter_unit.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         req_push / req_full   req_kind, req_data_byte
// rsp_      out        rsp_pop / rsp_empty   key, byte count, run count, last, error
// csr_      in         csr_valid / csr_ready csr_merge_mode
//
// A plain byte word is taken every cycle. A newline or end-of-input word holds
// req_full while the line is closed, and then for as long as the back end works
// through each queued command: taking it, a read and a capture state per key
// byte (one read port) and a push state per piece, and longer when the result
// queue is full. Reset is synchronous and needs no clearing pass.
module sorted_line_dedup_counter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_key_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic [31:0] rsp_run_count,
   output logic        rsp_run_last,
   output logic [1:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_merge_mode
);
   import sld_pkg::*;

   rd_req_type rd_req;
   logic [7:0] rd_data;
   logic cmd_push, cmd_pop, q_not_empty, back_active;
   cmd_type push_cmd, head_cmd;
   piece_type piece;

   assign csr_ready = 1'b1;

   sld_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .kind           (req_kind),
      .data_byte      (req_data_byte),
      .full           (req_full),
      .csr_valid      (csr_valid),
      .csr_merge_mode (csr_merge_mode),
      .back_busy      (q_not_empty || back_active),
      .back_rd        (rd_req),
      .rd_data        (rd_data),
      .cmd_push       (cmd_push),
      .cmd            (push_cmd)
   );

   sld_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .pop       (cmd_pop),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   sld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .busy      (back_active),
      .rd_req    (rd_req),
      .rd_data   (rd_data),
      .out_pop   (rsp_pop),
      .out_empty (rsp_empty),
      .out_piece (piece)
   );

   assign rsp_key_bytes  = piece.key;
   assign rsp_byte_count = piece.nbytes;
   assign rsp_run_count  = piece.count;
   assign rsp_run_last   = piece.last;
   assign rsp_error_code = piece.code;
endmodule
